FILE: rtl/core/hcieq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcieq_pkg
// Types, codes and microcode for the HCI command/event queue core.
// ----------------------------------------------------------------------------
package hcieq_pkg;

  // Request type codes
  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_COMMAND = 2'd1;
  localparam logic [1:0] REQ_POLL    = 2'd2;

  // HCI codes
  localparam logic [7:0]  PKT_EVENT             = 8'h04;
  localparam logic [7:0]  EVT_COMMAND_COMPLETE  = 8'h0E;
  localparam logic [7:0]  NUM_CMD_CREDITS       = 8'h01;
  localparam logic [7:0]  STATUS_SUCCESS        = 8'h00;
  localparam logic [15:0] OP_READ_LOCAL_VERSION = 16'h1001;
  localparam logic [15:0] OP_READ_BD_ADDR       = 16'h1009;

  // Parameter length byte and total length of each event form
  localparam logic [7:0] PLEN_VERSION = 8'd12;
  localparam logic [7:0] PLEN_BDADDR  = 8'd10;
  localparam logic [7:0] PLEN_DEFAULT = 8'd4;
  localparam logic [3:0] LEN_VERSION  = 4'd15;
  localparam logic [3:0] LEN_BDADDR   = 4'd13;
  localparam logic [3:0] LEN_DEFAULT  = 4'd7;

  // Configuration register reset values
  localparam logic [47:0] DEVICE_ADDRESS_RST = 48'hDEAD_BEEF_0001;
  localparam logic [7:0]  VERSION_CODE_RST   = 8'h09;

  // Register select (paddr bit 3)
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_VERSION_CODE   = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] opcode;
  } hci_req_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] data_byte;
    logic [3:0] event_length;
    logic       last;
  } hci_rsp_t;

  // Microprogram steps
  typedef enum logic [3:0] {
    S_INIT       = 4'd0,
    S_REJECT     = 4'd1,
    S_CMD_CHK    = 4'd2,
    S_CMD_WR     = 4'd3,
    S_CMD_COMMIT = 4'd4,
    S_CMD_ACK    = 4'd5,
    S_POLL_CHK   = 4'd6,
    S_POLL_PRIME = 4'd7,
    S_POLL_EMIT  = 4'd8,
    S_POLL_POP   = 4'd9
  } step_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_FULL,
    COND_EMPTY,
    COND_WR_MORE,
    COND_RD_MORE
  } cond_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ACK0,
    EMIT_ACK1,
    EMIT_BYTE
  } emit_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_e;

  typedef struct packed {
    cond_e   cond;
    step_e   target;
    emit_e   emit;
    cnt_op_e cnt_op;
    logic    wr_byte;
    logic    commit;
    logic    ld_len;
    logic    pop;
    logic    init;
    logic    done;
  } ctrl_t;

  localparam ctrl_t CTRL_IDLE = '{
    cond: COND_NEVER, target: S_INIT, emit: EMIT_NONE, cnt_op: CNT_HOLD,
    wr_byte: 1'b0, commit: 1'b0, ld_len: 1'b0, pop: 1'b0, init: 1'b0,
    done: 1'b0
  };

  // Control store
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = CTRL_IDLE;
    unique case (s)
      S_INIT: begin
        w.init = 1'b1;
        w.emit = EMIT_ACK1;
        w.done = 1'b1;
      end
      S_REJECT: begin
        w.emit = EMIT_ACK0;
        w.done = 1'b1;
      end
      S_CMD_CHK: begin
        w.cond   = COND_FULL;
        w.target = S_CMD_ACK;
        w.cnt_op = CNT_CLEAR;
      end
      S_CMD_WR: begin
        w.wr_byte = 1'b1;
        w.cnt_op  = CNT_INC;
        w.cond    = COND_WR_MORE;
        w.target  = S_CMD_WR;
      end
      S_CMD_COMMIT: begin
        w.commit = 1'b1;
      end
      S_CMD_ACK: begin
        w.emit = EMIT_ACK1;
        w.done = 1'b1;
      end
      S_POLL_CHK: begin
        w.cond   = COND_EMPTY;
        w.target = S_REJECT;
        w.cnt_op = CNT_CLEAR;
        w.ld_len = 1'b1;
      end
      S_POLL_PRIME: begin
        w.cnt_op = CNT_INC;
      end
      S_POLL_EMIT: begin
        w.emit   = EMIT_BYTE;
        w.cnt_op = CNT_INC;
        w.cond   = COND_RD_MORE;
        w.target = S_POLL_EMIT;
      end
      // final event byte goes out with the pop
      S_POLL_POP: begin
        w.emit = EMIT_BYTE;
        w.pop  = 1'b1;
        w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  // Total event length for an opcode
  function automatic logic [3:0] event_len(logic [15:0] op);
    logic [3:0] n;
    if (op == OP_READ_LOCAL_VERSION) n = LEN_VERSION;
    else if (op == OP_READ_BD_ADDR)  n = LEN_BDADDR;
    else                             n = LEN_DEFAULT;
    return n;
  endfunction

  // Byte idx of the Command Complete event for an opcode
  function automatic logic [7:0] event_byte(logic [3:0] idx, logic [15:0] op,
                                            logic [47:0] bd_addr, logic [7:0] ver);
    logic       is_ver;
    logic       is_bd;
    logic [7:0] b;
    is_ver = (op == OP_READ_LOCAL_VERSION);
    is_bd  = (op == OP_READ_BD_ADDR);
    b      = 8'h00;
    case (idx)
      4'd0: b = PKT_EVENT;
      4'd1: b = EVT_COMMAND_COMPLETE;
      4'd2: b = is_ver ? PLEN_VERSION : (is_bd ? PLEN_BDADDR : PLEN_DEFAULT);
      4'd3: b = NUM_CMD_CREDITS;
      4'd4: b = op[7:0];
      4'd5: b = op[15:8];
      4'd6: b = STATUS_SUCCESS;
      4'd7: b = is_ver ? ver : (is_bd ? bd_addr[47:40] : 8'h00);
      4'd8: b = is_bd ? bd_addr[39:32] : 8'h00;
      4'd9: b = is_bd ? bd_addr[31:24] : 8'h00;
      4'd10: b = is_bd ? bd_addr[23:16] : 8'h00;
      4'd11: b = is_bd ? bd_addr[15:8] : 8'h00;
      4'd12: b = is_bd ? bd_addr[7:0] : 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/core/hci_command_event_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_command_event_queue_core
// Stub HCI controller: answers commands with Command Complete events kept in
// a ring of slots and streams them out on poll requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; results come out
// on rsp_o with rsp_valid_o high for one cycle each and cannot be stalled,
// so the receiver must take every result in the cycle it appears. The
// final result of a request has last set and busy drops in that same
// cycle, so the next request can be taken on the following edge. Init,
// rejected and unknown requests run only S_INIT or S_REJECT; a full-ring
// command runs S_CMD_CHK, S_CMD_ACK and an empty poll S_POLL_CHK, S_REJECT.
// A stored command writes its n event bytes (n = 7, 13 or 15), commits and
// acks; a nonempty poll primes, emits the n bytes and pops with the last.
// The single byte memory moves one event byte per cycle under the microcoded
// sequencer. The ring holds QUEUE_SLOTS-1 events; an event that finds it
// full is dropped. No clearing pass after reset: only written slots are read.
module hci_command_event_queue_core #(
  parameter int QUEUE_SLOTS = 16,
  parameter int SLOT_BYTES  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                start,
  output logic                busy,
  input  hcieq_pkg::hci_req_t req_i,
  // result channel
  output logic                rsp_valid_o,
  output hcieq_pkg::hci_rsp_t rsp_o
);
  import hcieq_pkg::*;

  localparam int SlotW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int AddrW = $clog2(QUEUE_SLOTS * SLOT_BYTES);
  localparam int MemDepth = QUEUE_SLOTS * SLOT_BYTES;
  localparam logic [AddrW-1:0] SlotStride = AddrW'(SLOT_BYTES);
  localparam logic [SlotW-1:0] SlotLast   = SlotW'(QUEUE_SLOTS - 1);

  // configuration registers
  logic [47:0] dev_addr_q;
  logic [7:0]  version_q;
  logic        cfg_wr;

  // sequencer
  logic     busy_q, busy_d;
  step_e    step_q, step_d;
  hci_req_t req_q;
  ctrl_t    ctrl;
  logic     jump;

  // datapath state
  logic [SlotW-1:0] ws_q, ws_d;
  logic [SlotW-1:0] rs_q, rs_d;
  logic [SlotW-1:0] ws_next, rs_next;
  logic             en_q, en_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [3:0]       nrd_q, nrd_d;
  logic [3:0]       ncmd;
  logic             full, empty;

  // memories
  logic [7:0]       byte_mem_q [MemDepth];
  logic [3:0]       len_mem_q  [QUEUE_SLOTS];
  logic [7:0]       byte_rd_q;
  logic [3:0]       len_rd_q;
  logic [AddrW-1:0] wr_addr, rd_addr;

  // result register
  logic     rsp_valid_q, rsp_valid_d;
  hci_rsp_t rsp_q, rsp_d;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEVICE_ADDRESS_RST;
      version_q  <= VERSION_CODE_RST;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_DEVICE_ADDRESS) dev_addr_q <= pwdata[47:0];
      else                                version_q  <= pwdata[7:0];
    end
  end

  always_comb begin
    if (paddr[3] == REG_VERSION_CODE) prdata = {56'd0, version_q};
    else                              prdata = {16'd0, dev_addr_q};
  end

  // ---------------- control word and conditions ----------------
  assign ctrl    = busy_q ? ucode(step_q) : CTRL_IDLE;
  assign ws_next = (ws_q == SlotLast) ? '0 : ws_q + 1'b1;
  assign rs_next = (rs_q == SlotLast) ? '0 : rs_q + 1'b1;
  assign full    = (ws_next == rs_q);
  assign empty   = (ws_q == rs_q);
  assign ncmd    = event_len(req_q.opcode);

  // read loop stops one byte early; the last byte leaves with the pop step
  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:   jump = 1'b0;
      COND_FULL:    jump = full;
      COND_EMPTY:   jump = empty;
      COND_WR_MORE: jump = (cnt_q != ncmd - 4'd1);
      COND_RD_MORE: jump = (cnt_q != nrd_q - 4'd1);
      default:      jump = 1'b0;
    endcase
  end

  // ---------------- next step ----------------
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (start) begin
        busy_d = 1'b1;
        unique case (req_i.req_type)
          REQ_INIT:    step_d = S_INIT;
          REQ_COMMAND: step_d = en_q ? S_CMD_CHK : S_REJECT;
          REQ_POLL:    step_d = S_POLL_CHK;
          default:     step_d = S_REJECT;
        endcase
      end
    end else if (ctrl.done) begin
      busy_d = 1'b0;
    end else if (jump) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_e'(step_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= S_INIT;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (start && !busy_q) req_q <= req_i;
  end

  assign busy = busy_q;

  // ---------------- datapath updates ----------------
  always_comb begin
    ws_d  = ws_q;
    rs_d  = rs_q;
    en_d  = en_q;
    cnt_d = cnt_q;
    nrd_d = nrd_q;
    if (ctrl.init) begin
      ws_d = '0;
      rs_d = '0;
      en_d = 1'b1;
    end
    if (ctrl.commit) ws_d = ws_next;
    if (ctrl.pop)    rs_d = rs_next;
    if (ctrl.ld_len) nrd_d = len_rd_q;
    unique case (ctrl.cnt_op)
      CNT_HOLD:  cnt_d = cnt_q;
      CNT_CLEAR: cnt_d = '0;
      CNT_INC:   cnt_d = cnt_q + 4'd1;
      default:   cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
      rs_q <= '0;
      en_q <= 1'b0;
    end else begin
      ws_q <= ws_d;
      rs_q <= rs_d;
      en_q <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    nrd_q <= nrd_d;
  end

  // ---------------- event memories ----------------
  assign wr_addr = AddrW'(ws_q) * SlotStride + AddrW'(cnt_q);
  assign rd_addr = AddrW'(rs_q) * SlotStride + AddrW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (ctrl.wr_byte) begin
      byte_mem_q[wr_addr] <= event_byte(cnt_q, req_q.opcode, dev_addr_q, version_q);
    end
    byte_rd_q <= byte_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) len_mem_q[ws_q] <= ncmd;
    len_rd_q <= len_mem_q[rs_q];
  end

  // ---------------- result register ----------------
  always_comb begin
    rsp_d       = '0;
    rsp_valid_d = 1'b1;
    unique case (ctrl.emit)
      EMIT_NONE: rsp_valid_d = 1'b0;
      EMIT_ACK0: rsp_d.last = 1'b1;
      EMIT_ACK1: begin
        rsp_d.accepted = 1'b1;
        rsp_d.last     = 1'b1;
      end
      EMIT_BYTE: begin
        rsp_d.accepted     = 1'b1;
        rsp_d.data_byte    = byte_rd_q;
        rsp_d.event_length = nrd_q;
        rsp_d.last         = (cnt_q == nrd_q);
      end
      default: rsp_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_valid_q <= 1'b0;
    else         rsp_valid_q <= rsp_valid_d;
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // ---------------- assertions ----------------
  // a taken request keeps the sequencer busy on the next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy_q |=> busy_q)
    else $error("request taken but sequencer not busy");

  // results only come from a running request
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(busy_q))
    else $error("result without a running request");

  // busy drops exactly with the final result
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> rsp_valid_o && rsp_o.last)
    else $error("sequencer finished without a last result");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.last |-> !busy_q)
    else $error("last result while still busy");

  // ring pointers stay within the slot range
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(ws_q) < QUEUE_SLOTS) && (int'(rs_q) < QUEUE_SLOTS))
    else $error("slot pointer out of range");

endmodule
